>>> design/sus_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sus_pkg: shared types and constants for the sorted unique set insert block
// Port widths that are fixed for the request and response channels, and the
// command group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package sus_pkg;

   // Fixed channel payload widths
   localparam int KEY_PORT_W = 32;
   localparam int POS_W      = 9;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // request accepted: latch key and search result
      logic commit;    // update the table and load the response register
   } sus_cmd_type;

endpackage : sus_pkg
`default_nettype wire

>>> design/sus_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sus_if: request and response channel interfaces
// Valid/ready channels; a request moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface sus_req_if
   import sus_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [KEY_PORT_W-1:0] key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface : sus_req_if

interface sus_rsp_if
   import sus_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;
   logic             inserted;
   logic             full_res;
   logic [POS_W-1:0] entry_count;

   modport source (output valid, output position, output inserted,
                   output full_res, output entry_count, input ready);
   modport sink   (input valid, input position, input inserted,
                   input full_res, input entry_count, output ready);
endinterface : sus_rsp_if
`default_nettype wire

>>> design/sus_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sus_ctrl: request sequencing state machine
// Accepts a request in IDLE, then commits it once the response register is
// free, and handles the response valid flag.
// ----------------------------------------------------------------------------
module sus_ctrl
   import sus_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output sus_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // Command decode
   always_comb begin
      cmd.capture = req_valid && req_ready_ff;
      cmd.commit  = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_ready) rsp_valid_ff <= 1'b0;
               if (cmd.capture) begin
                  state_ff     <= ST_COMMIT;
                  req_ready_ff <= 1'b0;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            ST_COMMIT: begin
               if (cmd.commit) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule : sus_ctrl
`default_nettype wire

>>> design/sus_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sus_datapath: row of key cells with parallel compare and shift insert
// Every cell compares its key with the incoming key; the less-than vector is
// a thermometer code whose edge gives the lower bound. On an inserting commit,
// cells above the bound take their lower neighbor and the bound cell the key.
// ----------------------------------------------------------------------------
module sus_datapath
   import sus_pkg::*;
#(
   parameter int CAPACITY  = 256,
   parameter int KEY_WIDTH = 32
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sus_cmd_type           cmd,
   input  wire logic [KEY_PORT_W-1:0] req_key,
   output logic [POS_W-1:0]           rsp_position,
   output logic                       rsp_inserted,
   output logic                       rsp_full_res,
   output logic [POS_W-1:0]           rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Table state
   logic [KEY_WIDTH-1:0] cell_ff [CAPACITY];
   logic [CAPACITY-1:0]  valid_ff;
   logic [CNT_W-1:0]     count_ff;

   // Captured request
   logic [KEY_WIDTH-1:0] key_ff;
   logic [CNT_W-1:0]     pos_ff;
   logic                 hit_ff;
   logic                 full_ff;

   // Response payload
   logic [POS_W-1:0] rsp_pos_ff;
   logic             rsp_ins_ff;
   logic             rsp_full_ff;
   logic [POS_W-1:0] rsp_cnt_ff;

   logic [KEY_WIDTH+KEY_PORT_W-1:0] key_ext;
   logic [KEY_WIDTH-1:0]            key_w;
   logic [CAPACITY-1:0]             lt_w;
   logic [CAPACITY-1:0]             eq_w;
   logic [CAPACITY:0]               lt_ext;
   logic [CAPACITY:0]               hot_w;
   logic [CNT_W-1:0]                pos_w;
   logic                            do_ins;
   logic [CNT_W-1:0]                count_next;
   logic [POS_W+CNT_W-1:0]          pos_ext;
   logic [POS_W+CNT_W-1:0]          cnt_ext;

   // Key at the table width: low bits of the port, zero-extended if wider
   assign key_ext = {{KEY_WIDTH{1'b0}}, req_key};
   assign key_w   = key_ext[KEY_WIDTH-1:0];

   // Per-cell compare
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
      assign lt_w[i] = valid_ff[i] && (cell_ff[i] < key_w);
      assign eq_w[i] = valid_ff[i] && (cell_ff[i] == key_w);
   end

   // Edge of the thermometer code marks the lower bound
   assign lt_ext   = {1'b0, lt_w};
   assign hot_w[0] = !lt_ext[0];
   for (genvar i = 1; i <= CAPACITY; i++) begin : g_edge
      assign hot_w[i] = !lt_ext[i] && lt_ext[i-1];
   end

   // One-hot to index
   always_comb begin
      pos_w = '0;
      for (int i = 0; i <= CAPACITY; i++) begin
         pos_w = pos_w | ({CNT_W{hot_w[i]}} & CNT_W'(i));
      end
   end

   // Latch search result on accept
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff  <= key_w;
         pos_ff  <= pos_w;
         hit_ff  <= |eq_w;
         full_ff <= (count_ff == CNT_W'(CAPACITY));
      end
   end

   assign do_ins     = !hit_ff && !full_ff;
   assign count_next = count_ff + {{(CNT_W-1){1'b0}}, do_ins};

   // Shift insert, one cell each
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      always_ff @(posedge clock) begin
         if (cmd.commit && do_ins) begin
            if (CNT_W'(i) == pos_ff) begin
               cell_ff[i] <= key_ff;
            end else if (i > 0 && CNT_W'(i) > pos_ff) begin
               cell_ff[i] <= cell_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   // Fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit && do_ins) begin
         valid_ff <= {valid_ff[CAPACITY-2:0], 1'b1};
         count_ff <= count_next;
      end
   end

   // Response register
   assign pos_ext = {{POS_W{1'b0}}, pos_ff};
   assign cnt_ext = {{POS_W{1'b0}}, count_next};

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_pos_ff  <= pos_ext[POS_W-1:0];
         rsp_ins_ff  <= do_ins;
         rsp_full_ff <= !hit_ff && full_ff;
         rsp_cnt_ff  <= cnt_ext[POS_W-1:0];
      end
   end

   assign rsp_position    = rsp_pos_ff;
   assign rsp_inserted    = rsp_ins_ff;
   assign rsp_full_res    = rsp_full_ff;
   assign rsp_entry_count = rsp_cnt_ff;

endmodule : sus_datapath
`default_nettype wire

>>> design/sorted_unique_set_insert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_set_insert: sorted table of unique keys, insert only
// Keeps up to CAPACITY keys in ascending unsigned order in a row of cells and
// inserts each requested key at its lower bound unless present or full.
//
//   channel  dir  handshake     payload
//   req_ch   in   valid/ready   key
//   rsp_ch   out  valid/ready   position, inserted, full_res, entry_count
//
// Each request has an accept step that compares the key against all cells in
// parallel and a commit step that shifts the table and loads the response.
// A response still waiting does not block the next accept; the commit cycle
// waits while the response register is held by rsp_ch.ready low.
// Synchronous reset empties the table at once; no clearing pass is needed.
// req_ch.ready is low during reset, until the controller first raises it,
// and from each accept until its commit.
// ----------------------------------------------------------------------------
module sorted_unique_set_insert
   import sus_pkg::*;
#(
   parameter int CAPACITY  = 256,
   parameter int KEY_WIDTH = 32
)(
   input  wire logic  clock,
   input  wire logic  reset,
   sus_req_if.sink    req_ch,
   sus_rsp_if.source  rsp_ch
);

   sus_cmd_type cmd;
   logic        ctrl_req_ready;
   logic        ctrl_rsp_valid;

   // Controller
   sus_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // Datapath
   sus_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_key         (req_ch.key),
      .rsp_position    (rsp_ch.position),
      .rsp_inserted    (rsp_ch.inserted),
      .rsp_full_res    (rsp_ch.full_res),
      .rsp_entry_count (rsp_ch.entry_count)
   );

   assign req_ch.ready = ctrl_req_ready;
   assign rsp_ch.valid = ctrl_rsp_valid;

endmodule : sorted_unique_set_insert
`default_nettype wire

>>> tb/sv/tb_sorted_unique_set_insert.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_unique_set_insert: self-checking bench for the sorted key table
// Sends keys over the request channel and checks every response against a
// local model of the sorted set: lower-bound position, insert, full flag and
// count. Covers empty, duplicate and full tables, with random stalls on both
// channels and one long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_sorted_unique_set_insert;
   import sus_pkg::*;

   localparam int SET_CAPACITY = 256;
   localparam int KEY_W        = 32;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int RANDOM_ITEMS = 730;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             inserted;
      logic             full_res;
      logic [POS_W-1:0] entry_count;
   } insert_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sus_req_if req_ch ();
   sus_rsp_if rsp_ch ();

   sorted_unique_set_insert #(
      .CAPACITY  (SET_CAPACITY),
      .KEY_WIDTH (KEY_W)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   // Local copy of the sorted set
   logic [KEY_W-1:0]      set_keys [SET_CAPACITY];
   int                    set_size = 0;

   logic [KEY_PORT_W-1:0] pending_keys [$];
   insert_result_type     expected_results [$];
   int                    req_count    = 0;
   int                    total_keys   = 0;
   int                    error_count  = 0;
   int                    quiet_cycles = 0;
   logic                  req_fire_ff  = 1'b0;

   // Receiver hold-off state
   bit                    hold_active = 1'b0;
   bit                    hold_done   = 1'b0;
   int                    hold_left   = 0;

   // No idling on either side within this window of requests
   wire calm_stretch = (req_count >= 450) && (req_count < 600);

   // Lower-bound insert into the local set; returns the expected response
   function automatic insert_result_type predict_insert(input logic [KEY_W-1:0] key);
      insert_result_type res;
      int                lb;
      bit                hit;
      lb = 0;
      while (lb < set_size && set_keys[lb] < key)
         lb++;
      hit = (lb < set_size) && (set_keys[lb] == key);
      res.inserted = 1'b0;
      res.full_res = 1'b0;
      if (!hit) begin
         if (set_size >= SET_CAPACITY) begin
            res.full_res = 1'b1;
         end else begin
            for (int i = set_size; i > lb; i--)
               set_keys[i] = set_keys[i-1];
            set_keys[lb] = key;
            set_size++;
            res.inserted = 1'b1;
         end
      end
      res.position    = POS_W'(lb);
      res.entry_count = POS_W'(set_size);
      return res;
   endfunction

   task automatic check_response(input insert_result_type got);
      insert_result_type want;
      if (expected_results.size() == 0) begin
         error_count++;
         $display("%0t: unexpected response pos=%0d ins=%0b full=%0b count=%0d",
                  $time, got.position, got.inserted, got.full_res, got.entry_count);
      end else begin
         want = expected_results.pop_front();
         if (got.position != want.position) begin
            error_count++;
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, got.position);
         end
         if (got.inserted != want.inserted) begin
            error_count++;
            $display("%0t: inserted expected %0b actual %0b",
                     $time, want.inserted, got.inserted);
         end
         if (got.full_res != want.full_res) begin
            error_count++;
            $display("%0t: full_res expected %0b actual %0b",
                     $time, want.full_res, got.full_res);
         end
         if (got.entry_count != want.entry_count) begin
            error_count++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, got.entry_count);
         end
      end
   endtask

   // Monitor: requests feed the model, responses are checked
   always @(posedge clock) begin
      if (reset) begin
         req_fire_ff <= 1'b0;
      end else begin
         req_fire_ff <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(predict_insert(req_ch.key[KEY_W-1:0]));
            req_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready)
            check_response({rsp_ch.position, rsp_ch.inserted,
                            rsp_ch.full_res, rsp_ch.entry_count});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // Request driver: hold the key until taken, random gaps between requests
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.key   <= '0;
      end else if (!req_ch.valid || req_fire_ff) begin
         if (pending_keys.size() > 0 && (calm_stretch || $urandom_range(99) >= 33)) begin
            req_ch.valid <= 1'b1;
            req_ch.key   <= pending_keys.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls plus one long hold-off to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_active) begin
         hold_left--;
         if (hold_left == 0)
            hold_active = 1'b0;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && req_count >= 150) begin
         hold_done   = 1'b1;
         hold_active = 1'b1;
         hold_left   = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm_stretch || ($urandom_range(99) >= 33);
      end
   end

   // Watchdog on cycles with no transfer on either channel
   initial begin : watchdog
      wait (!reset);
      while (quiet_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [KEY_PORT_W-1:0] sent_keys [$];
      logic [KEY_PORT_W-1:0] k;
      int                    pick;

      req_ch.valid = 1'b0;
      req_ch.key   = '0;
      rsp_ch.ready = 1'b0;

      // Directed: empty table, both ends, duplicates, insert at front and middle
      sent_keys = '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
                    32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFE,
                    32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001,
                    32'h7FFF_FFFE};
      foreach (sent_keys[i])
         pending_keys.push_back(sent_keys[i]);

      // Random: fresh keys, repeats, neighbors of sent keys and small values.
      // The all-ones key is kept back so a full table can report position 256.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            k = $urandom;
            if (k == 32'hFFFF_FFFF)
               k = 32'hFFFF_FFFD;
         end else if (pick < 75) begin
            k = sent_keys[$urandom_range(sent_keys.size() - 1)];
         end else if (pick < 88) begin
            k = sent_keys[$urandom_range(sent_keys.size() - 1)];
            if ($urandom_range(1) && k < 32'hFFFF_FFFD)
               k = k + 1;
            else if (k > 0)
               k = k - 1;
         end else begin
            k = $urandom_range(40);
         end
         sent_keys.push_back(k);
         pending_keys.push_back(k);
      end

      // Table is full by now: key past the end, last entry, first entry
      pending_keys.push_back(32'hFFFF_FFFF);
      pending_keys.push_back(32'hFFFF_FFFE);
      pending_keys.push_back(32'h0000_0000);
      total_keys = pending_keys.size();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (req_count == total_keys);
      wait (expected_results.size() == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule : tb_sorted_unique_set_insert
